// ----- hw/rtl/expected_count_scatter_accumulate_top_defines.svh -----
// Assertion macros for the expected-count scatter accumulator.
// Used by the top level only; it needs signals named clk and rst_n in scope.
`ifndef EXPECTED_COUNT_SCATTER_ACCUMULATE_TOP_DEFINES_SVH
`define EXPECTED_COUNT_SCATTER_ACCUMULATE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECSA_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECSA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ecsa_pkg.sv -----
// Shared constants, types and arithmetic helpers of the scatter accumulator.
// No dependencies; the datapath, the top level and both testbench modules import it.
`default_nettype none

package ecsa_pkg;

  localparam int NUM_TAGS   = 4096;
  localparam int TAG_W      = 12;
  localparam int IDX_W      = $clog2(NUM_TAGS);
  localparam int CNT_W      = 24;
  localparam int PFB        = 16;
  localparam int PROB_W     = PFB + 1;
  localparam int Q_W        = PFB;
  localparam int QPROD_W    = 2 * PROB_W;
  localparam int MEAN_W     = CNT_W + PROB_W;
  localparam int VAR_W      = CNT_W + Q_W;
  localparam int SHR        = (PFB >= 16) ? PFB - 16 : 0;
  localparam int SHL        = (PFB < 16) ? 16 - PFB : 0;
  localparam int TERM_W     = MEAN_W + SHL;
  localparam int ACC_W      = 48;
  localparam int ACC_PAIR_W = 2 * ACC_W;

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PFB;
  localparam logic [ACC_W-1:0]  ACC_MAX  = '1;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_TAGS - 1);

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_EDGE  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } ecsa_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_READ
  } ecsa_state_t;

  typedef struct packed {
    logic start;
    logic mul;
  } ecsa_dp_ctl_t;

  // Converts a product in Q.PFB to Q.16, truncating extra fraction bits.
  function automatic logic [TERM_W-1:0] to_q16(input logic [MEAN_W-1:0] x);
    logic [TERM_W-1:0] t;
    t = TERM_W'(x >> SHR);
    return t << SHL;
  endfunction

  // Adds a term to an accumulator and clamps at the largest value.
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [TERM_W-1:0] term);
    logic [ACC_W:0] s;
    logic           big;
    big = (term > ACC_MAX);
    s   = {1'b0, acc} + (ACC_W + 1)'(term);
    return (big || s[ACC_W]) ? ACC_MAX : s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ecsa_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies; contents are not reset.
`default_nettype none

module ecsa_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ecsa_datapath.sv -----
// Arithmetic of an edge: the p*(1-p) term, the two count products and the
// saturating accumulation. Depends on ecsa_pkg.
`default_nettype none

module ecsa_datapath
  import ecsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire ecsa_dp_ctl_t          ctl,
  input  wire logic [PROB_W-1:0]     in_prob,
  input  wire logic [CNT_W-1:0]      cnt_rd,
  input  wire logic [ACC_PAIR_W-1:0] acc_rd,
  output logic      [ACC_PAIR_W-1:0] acc_new
);

  logic [PROB_W-1:0]  p_clamp;
  logic [PROB_W-1:0]  one_minus;
  logic [QPROD_W-1:0] qprod;
  logic [PROB_W-1:0]  p_r;
  logic [Q_W-1:0]     q_r;
  logic [MEAN_W-1:0]  mean_r;
  logic [VAR_W-1:0]   var_r;

  // Probabilities above one count as one.
  always_comb begin
    p_clamp   = (in_prob > PROB_ONE) ? PROB_ONE : in_prob;
    one_minus = PROB_ONE - p_clamp;
    qprod     = QPROD_W'(one_minus) * QPROD_W'(p_clamp);
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      p_r <= p_clamp;
      q_r <= qprod[PFB +: Q_W];
    end
    if (ctl.mul) begin
      mean_r <= MEAN_W'(cnt_rd) * MEAN_W'(p_r);
      var_r  <= VAR_W'(cnt_rd) * VAR_W'(q_r);
    end
  end

  // Mean sits in the upper half of an accumulator word, variance in the lower.
  assign acc_new = {sat_add(acc_rd[ACC_PAIR_W-1:ACC_W], to_q16(mean_r)),
                    sat_add(acc_rd[ACC_W-1:0], to_q16(MEAN_W'(var_r)))};

endmodule

`default_nettype wire

// ----- hw/rtl/expected_count_scatter_accumulate_top.sv -----
// Top level of the expected-count scatter accumulator: request sequencer,
// the true-count RAM and the accumulator RAM. Depends on ecsa_pkg, ecsa_ram,
// ecsa_datapath and the assertion macro header.
//
//   Channel  Ports                                               Direction
//   in       in_valid, in_stall, in_req_type, in_source_tag,     into block
//            in_observed_tag, in_count_value, in_edge_prob
//   out      out_valid, out_stall, out_read_tag, out_mean_count, out of block
//            out_variance_count
//
// A load word is done when taken; an edge word passes through reading both
// RAMs, the multiply and the write-back; a read word through the RAM read
// and any wait while the previous result still sits in the output register.
// With a single accumulator read-modify-write, one word is in flight at a time.
// A clear word, and reset, start a sweep that zeroes the accumulator RAM one
// entry per cycle, all NUM_TAGS (4096) entries, during which in_stall is high.
// A finished result waits in the output register while new words come in.
`default_nettype none

`include "expected_count_scatter_accumulate_top_defines.svh"

module expected_count_scatter_accumulate_top
  import ecsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [TAG_W-1:0]  in_source_tag,
  input  wire logic [TAG_W-1:0]  in_observed_tag,
  input  wire logic [CNT_W-1:0]  in_count_value,
  input  wire logic [PROB_W-1:0] in_edge_prob,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [TAG_W-1:0]  out_read_tag,
  output logic      [ACC_W-1:0]  out_mean_count,
  output logic      [ACC_W-1:0]  out_variance_count
);

  ecsa_state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers of the word in flight and of the result.
  logic [TAG_W-1:0] obs_r;
  logic             obs_ok_r;
  logic [TAG_W-1:0] out_tag_r;
  logic [ACC_W-1:0] out_mean_r;
  logic [ACC_W-1:0] out_var_r;

  logic             in_fire;
  logic             out_fire;
  logic             out_load;
  logic             src_ok;
  logic             obs_ok;
  ecsa_req_t        req;

  logic                  cnt_wr_en;
  logic                  cnt_rd_en;
  logic [CNT_W-1:0]      cnt_rd;
  logic                  acc_wr_en;
  logic [IDX_W-1:0]      acc_wr_addr;
  logic [ACC_PAIR_W-1:0] acc_wr_data;
  logic                  acc_rd_en;
  logic [ACC_PAIR_W-1:0] acc_rd;
  logic [ACC_PAIR_W-1:0] acc_new;
  ecsa_dp_ctl_t          dp_ctl;

  assign req      = ecsa_req_t'(in_req_type);
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign src_ok   = (32'(in_source_tag) < NUM_TAGS);
  assign obs_ok   = (32'(in_observed_tag) < NUM_TAGS);

  // Sequencer: next state, RAM strobes and datapath controls.
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    cnt_wr_en   = 1'b0;
    cnt_rd_en   = 1'b0;
    acc_rd_en   = 1'b0;
    acc_wr_en   = 1'b0;
    acc_wr_addr = obs_r[IDX_W-1:0];
    acc_wr_data = acc_new;
    out_load    = 1'b0;
    dp_ctl      = '0;
    case (state_r)
      ST_CLEAR: begin
        acc_wr_en   = 1'b1;
        acc_wr_addr = clr_idx_r;
        acc_wr_data = '0;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (req)
            REQ_LOAD: begin
              cnt_wr_en = src_ok;
            end
            REQ_EDGE: begin
              // Out-of-range edges are dropped without a RAM access.
              if (src_ok && obs_ok) begin
                cnt_rd_en    = 1'b1;
                acc_rd_en    = 1'b1;
                dp_ctl.start = 1'b1;
                state_nxt    = ST_MUL;
              end
            end
            REQ_CLEAR: begin
              clr_idx_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            REQ_READ: begin
              acc_rd_en = 1'b1;
              state_nxt = ST_READ;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL: begin
        dp_ctl.mul = 1'b1;
        state_nxt  = ST_WB;
      end
      ST_WB: begin
        acc_wr_en = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        // The RAM read data holds, so the result can wait for the output slot.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      obs_r    <= in_observed_tag;
      obs_ok_r <= obs_ok;
    end
    if (out_load) begin
      out_tag_r  <= obs_r;
      out_mean_r <= obs_ok_r ? acc_rd[ACC_PAIR_W-1:ACC_W] : '0;
      out_var_r  <= obs_ok_r ? acc_rd[ACC_W-1:0] : '0;
    end
  end

  ecsa_ram #(
    .DEPTH (NUM_TAGS),
    .WIDTH (CNT_W)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (in_source_tag[IDX_W-1:0]),
    .wr_data (in_count_value),
    .rd_en   (cnt_rd_en),
    .rd_addr (in_source_tag[IDX_W-1:0]),
    .rd_data (cnt_rd)
  );

  ecsa_ram #(
    .DEPTH (NUM_TAGS),
    .WIDTH (ACC_PAIR_W)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_wr_en),
    .wr_addr (acc_wr_addr),
    .wr_data (acc_wr_data),
    .rd_en   (acc_rd_en),
    .rd_addr (in_observed_tag[IDX_W-1:0]),
    .rd_data (acc_rd)
  );

  ecsa_datapath u_datapath (
    .clk     (clk),
    .ctl     (dp_ctl),
    .in_prob (in_edge_prob),
    .cnt_rd  (cnt_rd),
    .acc_rd  (acc_rd),
    .acc_new (acc_new)
  );

  assign out_valid          = out_valid_r;
  assign out_read_tag       = out_tag_r;
  assign out_mean_count     = out_mean_r;
  assign out_variance_count = out_var_r;

  // No word may be taken while the accumulator RAM is being written.
  `ECSA_ASSERT_SAME(a_no_accept_on_write, acc_wr_en, in_stall, "word accepted during RAM write")
  // An accepted read word always moves to the result stage.
  `ECSA_ASSERT_NEXT(a_read_seq, in_fire && (in_req_type == REQ_READ), state_r == ST_READ, "read word lost")
  // The multiply cycle is always followed by the write-back.
  `ECSA_ASSERT_NEXT(a_mul_then_wb, state_r == ST_MUL, state_r == ST_WB, "edge write-back skipped")
  // The clearing sweep runs to the last entry.
  `ECSA_ASSERT_NEXT(a_clear_runs, (state_r == ST_CLEAR) && (clr_idx_r != LAST_IDX), state_r == ST_CLEAR, "clear sweep cut short")

endmodule

`default_nettype wire

// ----- tb/scatter_accumulate_checker.sv -----
`timescale 1ns / 100ps
// Checker for the expected-count scatter accumulator: watches both channels,
// predicts every read result and compares it. Depends on ecsa_pkg only.
module scatter_accumulate_checker
  import ecsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [TAG_W-1:0]  in_source_tag,
  input  logic [TAG_W-1:0]  in_observed_tag,
  input  logic [CNT_W-1:0]  in_count_value,
  input  logic [PROB_W-1:0] in_edge_prob,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [TAG_W-1:0]  out_read_tag,
  input  logic [ACC_W-1:0]  out_mean_count,
  input  logic [ACC_W-1:0]  out_variance_count,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [ACC_W-1:0] mean;
    logic [ACC_W-1:0] variance;
  } tag_totals_t;

  logic [CNT_W-1:0] true_counts   [NUM_TAGS];
  logic [ACC_W-1:0] mean_sums     [NUM_TAGS];
  logic [ACC_W-1:0] variance_sums [NUM_TAGS];
  tag_totals_t      awaited_totals [$];

  function automatic logic [ACC_W-1:0] add_clamped(input logic [ACC_W-1:0] acc,
                                                   input logic [63:0] term);
    logic [64:0] total;
    total = 65'(acc) + 65'(term);
    return (total > 65'(ACC_MAX)) ? ACC_MAX : total[ACC_W-1:0];
  endfunction

  // Products come out in Q.PFB; the accumulators hold Q.16.
  function automatic logic [63:0] scale_to_q16(input logic [63:0] raw);
    if (PFB >= 16) return raw >> (PFB - 16);
    return raw << (16 - PFB);
  endfunction

  task automatic zero_sums();
    for (int t = 0; t < NUM_TAGS; t++) begin
      mean_sums[t]     = '0;
      variance_sums[t] = '0;
    end
  endtask

  // Every tag is 12 bits wide and the tables hold 4096 entries, so no word
  // can name a tag beyond the tables.
  task automatic predict_word(input ecsa_req_t req, input logic [TAG_W-1:0] src,
                              input logic [TAG_W-1:0] obs, input logic [CNT_W-1:0] cnt,
                              input logic [PROB_W-1:0] prob);
    logic [PROB_W-1:0] p;
    logic [63:0]       count64;
    logic [63:0]       spread;
    tag_totals_t       totals;
    p = (prob > PROB_ONE) ? PROB_ONE : prob;
    case (req)
      REQ_LOAD: true_counts[src] = cnt;
      REQ_EDGE: begin
        count64 = 64'(true_counts[src]);
        // (1-p)*p is truncated to the probability format before scaling by c.
        spread = ((64'(PROB_ONE) - 64'(p)) * 64'(p)) >> PFB;
        mean_sums[obs] = add_clamped(mean_sums[obs], scale_to_q16(count64 * 64'(p)));
        variance_sums[obs] = add_clamped(variance_sums[obs], scale_to_q16(count64 * spread));
      end
      REQ_CLEAR: zero_sums();
      REQ_READ: begin
        totals.tag      = obs;
        totals.mean     = mean_sums[obs];
        totals.variance = variance_sums[obs];
        awaited_totals.push_back(totals);
      end
      default: ;
    endcase
  endtask

  task automatic note_failure(input string what, input tag_totals_t want,
                              input tag_totals_t seen);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected tag %0h mean %0h variance %0h, got tag %0h mean %0h variance %0h",
               $time, what, want.tag, want.mean, want.variance,
               seen.tag, seen.mean, seen.variance);
  endtask

  always @(posedge clk) begin
    tag_totals_t seen;
    tag_totals_t want;
    if (!rst_n) begin
      awaited_totals.delete();
      zero_sums();
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{out_read_tag, out_mean_count, out_variance_count};
        if (awaited_totals.size() == 0) begin
          note_failure("result word with no read waiting", '0, seen);
        end else begin
          want = awaited_totals.pop_front();
          if (seen !== want) note_failure("result word mismatch", want, seen);
        end
      end
      if (in_valid && !in_stall)
        predict_word(ecsa_req_t'(in_req_type), in_source_tag, in_observed_tag,
                     in_count_value, in_edge_prob);
    end
    pending = awaited_totals.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the scatter accumulator testbench: clock, reset, stimulus, stall
// patterns, watchdog and verdict. Depends on ecsa_pkg, the block and the checker.
module testbench;
  import ecsa_pkg::*;

  // A clear word (and reset) sweeps 4096 entries with the input stalled, and
  // the result side has a long output hold; the watchdog allows several
  // times the longer of the two without any word moving on either channel.
  localparam int STUCK_LIMIT = 20000;
  localparam int LONG_HOLD   = 200;
  localparam int TAIL_CYCLES = 16;

  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [PROB_W-1:0] P_HALF    = PROB_ONE >> 1;
  localparam logic [PROB_W-1:0] P_BELOW   = PROB_W'(PROB_ONE - 1);
  localparam logic [PROB_W-1:0] P_ABOVE   = PROB_W'(PROB_ONE + 1);

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic [1:0]        in_req_type        = REQ_LOAD;
  logic [TAG_W-1:0]  in_source_tag      = '0;
  logic [TAG_W-1:0]  in_observed_tag    = '0;
  logic [CNT_W-1:0]  in_count_value     = '0;
  logic [PROB_W-1:0] in_edge_prob       = '0;
  logic              out_valid;
  logic              out_stall          = 1'b0;
  logic [TAG_W-1:0]  out_read_tag;
  logic [ACC_W-1:0]  out_mean_count;
  logic [ACC_W-1:0]  out_variance_count;
  int                fail_count;
  int                pending;

  // Flags shared between the stimulus and the result side, always written
  // with nonblocking assignments so that the other process sees them cleanly
  // in the cycle after.
  logic quiet        = 1'b0;
  logic hold_outputs = 1'b0;
  logic outputs_held = 1'b0;

  int               stuck_cycles = 0;
  int               words_sent   = 0;
  int               gap_pct      = 0;
  bit               count_loaded [NUM_TAGS];
  logic [TAG_W-1:0] loaded_tags  [$];
  logic [TAG_W-1:0] hot_tags     [6];

  expected_count_scatter_accumulate_top u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_source_tag, .in_observed_tag,
    .in_count_value, .in_edge_prob,
    .out_valid, .out_stall, .out_read_tag, .out_mean_count, .out_variance_count
  );

  scatter_accumulate_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_source_tag, .in_observed_tag,
    .in_count_value, .in_edge_prob,
    .out_valid, .out_stall, .out_read_tag, .out_mean_count, .out_variance_count,
    .fail_count, .pending
  );

  always #6 clk = ~clk;

  // Field generators. Unused fields of a word are filled with noise so that
  // every input bit toggles even where the block ignores it.
  function automatic logic [TAG_W-1:0] any_tag();
    return TAG_W'($urandom);
  endfunction

  function automatic logic [CNT_W-1:0] any_count();
    return CNT_W'($urandom);
  endfunction

  function automatic logic [PROB_W-1:0] any_prob();
    return PROB_W'($urandom);
  endfunction

  // Most tags come from a small working set so that edges pile up on the
  // same accumulators and reads see non-trivial sums.
  function automatic logic [TAG_W-1:0] pick_tag();
    return ($urandom_range(3) != 0) ? hot_tags[$urandom_range(5)] : any_tag();
  endfunction

  // An edge may only name a source whose true count has been loaded.
  function automatic logic [TAG_W-1:0] pick_source();
    return loaded_tags[$urandom_range(loaded_tags.size() - 1)];
  endfunction

  function automatic logic [CNT_W-1:0] random_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return any_count();
    if (roll < 70) return COUNT_MAX;
    if (roll < 80) return '0;
    return CNT_W'($urandom_range(1000));
  endfunction

  // Mostly proper probabilities, a share above one (the block clamps those)
  // and the corner values.
  function automatic logic [PROB_W-1:0] random_prob();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return PROB_W'($urandom_range(65536));
    if (roll < 75) return PROB_W'($urandom_range(131071, 65537));
    case ($urandom_range(5))
      0:       return '0;
      1:       return PROB_W'(1);
      2:       return P_HALF;
      3:       return P_BELOW;
      4:       return PROB_ONE;
      default: return '1;
    endcase
  endfunction

  // Offers one word and holds it until the block takes it. Called at a
  // rising edge and returns at one, with in_valid still high unless a gap
  // followed. The gap rate changes every 64 words, zero among the choices,
  // so that some stretches run without any idling.
  task automatic send_word(input ecsa_req_t req, input logic [TAG_W-1:0] src,
                           input logic [TAG_W-1:0] obs, input logic [CNT_W-1:0] cnt,
                           input logic [PROB_W-1:0] prob);
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_source_tag   <= src;
    in_observed_tag <= obs;
    in_count_value  <= cnt;
    in_edge_prob    <= prob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (words_sent % 64 == 0) gap_pct = 20 * int'($urandom_range(2));
    if (!quiet && int'($urandom_range(99)) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  task automatic load_count(input logic [TAG_W-1:0] tag, input logic [CNT_W-1:0] cnt);
    send_word(REQ_LOAD, tag, any_tag(), cnt, any_prob());
    if (!count_loaded[tag]) begin
      count_loaded[tag] = 1'b1;
      loaded_tags.push_back(tag);
    end
  endtask

  // The sender stops until every read has been answered. The checker updates
  // its count at rising edges, so it is looked at on falling edges.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Random mix: loads about a fifth, edges about half, reads the rest and a
  // rare clear, since each clear costs a full sweep of the accumulator RAM.
  task automatic mixed_words(input int n);
    int roll;
    repeat (n) begin
      if ($urandom_range(63) == 0) hot_tags[$urandom_range(5)] = any_tag();
      roll = $urandom_range(999);
      if (roll < 6)
        send_word(REQ_CLEAR, any_tag(), any_tag(), any_count(), any_prob());
      else if (roll < 220 || loaded_tags.size() == 0)
        load_count(pick_tag(), random_count());
      else if (roll < 700)
        send_word(REQ_EDGE, pick_source(), pick_tag(), any_count(), random_prob());
      else
        send_word(REQ_READ, any_tag(), pick_tag(), any_count(), any_prob());
    end
  endtask

  // Result side. Stall bursts and free bursts come in random order, with now
  // and then a long free stretch, once a long hold on request from the
  // stimulus, and no stalls at all once the run has gone quiet.
  initial begin : result_side
    int roll;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_outputs && !hold_done) begin
        out_stall    <= 1'b1;
        outputs_held <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        roll = $urandom_range(99);
        if (roll < 30) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(8, 1)) @(posedge clk);
        end else if (roll < 40) begin
          out_stall <= 1'b0;
          repeat (60) @(posedge clk);
        end else begin
          out_stall <= 1'b0;
          repeat ($urandom_range(8, 1)) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: a stretch with no word moving on either channel means the
  // block has hung, or a result never came.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [TAG_W-1:0] sat_src;
    logic [TAG_W-1:0] sat_dst;

    // Reset is held at the start; afterwards the block spends a full sweep
    // clearing its accumulators, during which it stalls the first word.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. True counts at the extremes, with alternating bit
    // patterns in tags and counts.
    load_count('0, '0);
    load_count('1, COUNT_MAX);
    load_count(TAG_W'('haaa), CNT_W'('h555555));
    load_count(TAG_W'('h555), CNT_W'('haaaaaa));
    hot_tags = '{'0, '1, TAG_W'('haaa), TAG_W'('h555), any_tag(), any_tag()};

    // Edges at probability one, zero, one half and just below one; a
    // probability above one, both the largest field value and one past one,
    // must act as one. An edge from a zero count adds nothing.
    send_word(REQ_EDGE, '1, '0, any_count(), PROB_ONE);
    send_word(REQ_EDGE, '1, '0, any_count(), '0);
    send_word(REQ_EDGE, '1, '1, any_count(), '1);
    send_word(REQ_EDGE, '1, '1, any_count(), P_HALF);
    send_word(REQ_EDGE, '0, TAG_W'('haaa), any_count(), PROB_W'(12345));
    send_word(REQ_EDGE, TAG_W'('haaa), TAG_W'('h555), any_count(), PROB_W'(1));
    send_word(REQ_EDGE, TAG_W'('h555), TAG_W'('h555), any_count(), P_BELOW);
    send_word(REQ_EDGE, TAG_W'('h555), TAG_W'('h555), any_count(), P_ABOVE);

    // Read back every touched tag and one that was never touched.
    send_word(REQ_READ, '1, '0, any_count(), any_prob());
    send_word(REQ_READ, '0, '1, any_count(), any_prob());
    send_word(REQ_READ, any_tag(), TAG_W'('h555), any_count(), any_prob());
    send_word(REQ_READ, any_tag(), TAG_W'('haaa), any_count(), any_prob());
    send_word(REQ_READ, any_tag(), TAG_W'(1), any_count(), any_prob());

    // A clear zeroes the sums but leaves the true counts in place.
    send_word(REQ_CLEAR, any_tag(), any_tag(), any_count(), any_prob());
    send_word(REQ_READ, any_tag(), '1, any_count(), any_prob());
    send_word(REQ_READ, any_tag(), TAG_W'('h555), any_count(), any_prob());

    mixed_words(150);

    // Long hold on the result side while reads keep coming: the first result
    // parks in the output register and the block then stalls its input.
    hold_outputs <= 1'b1;
    in_valid     <= 1'b0;
    @(posedge clk);
    while (!outputs_held) @(posedge clk);
    repeat (12) send_word(REQ_READ, any_tag(), pick_tag(), any_count(), any_prob());

    mixed_words(100);
    drain_results();
    mixed_words(150);
    drain_results();

    // Saturation: a maximal true count fanned into one tag many times with p
    // close to one. The mean sum saturates before the edges run out. Periodic
    // reads show the sums climbing and then the mean pinned at the maximum.
    sat_src = any_tag();
    sat_dst = any_tag();
    load_count(sat_src, COUNT_MAX);
    for (int i = 1; i <= 300; i++) begin
      send_word(REQ_EDGE, sat_src, sat_dst, any_count(),
                PROB_W'($urandom_range(65536, 64512)));
      if (i % 50 == 0) send_word(REQ_READ, any_tag(), sat_dst, any_count(), any_prob());
    end
    hot_tags[0] = sat_dst;

    mixed_words(250);

    // Last stretch with no idling on either side.
    quiet <= 1'b1;
    mixed_words(120);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
